[design/urc_pkg.sv]
// Shared types and constants for the uninitialized-read checker.
package urc_pkg;

  // fixed field widths of the stream beats
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 9;
  localparam int FUNC_W  = 2;

  localparam int S_TDATA_W = 40;
  localparam int S_TUSER_W = FUNC_W;
  localparam int M_TDATA_W = DATA_W;
  localparam int M_TUSER_W = 3;

  // default geometry
  localparam int ADDR_BITS_DEF = 16;
  localparam int LINE_BITS_DEF = 8;

  // command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // function codes on the input tuser
  localparam logic [FUNC_W-1:0] FUNC_READ    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd3;

  typedef enum logic [1:0] {
    OP_READ    = 2'd0,
    OP_WRITE   = 2'd1,
    OP_QUERY   = 2'd2,
    OP_RESTART = 2'd3
  } op_e;

  typedef struct packed {
    op_e                op;
    logic [ADDR_W-1:0]  addr;
    logic [DATA_W-1:0]  wdata;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic              inval;
    logic              ready;
    logic              uninit;
    logic [DATA_W-1:0] rdata;
  } res_t;

endpackage

[design/uninitialized_read_checker.sv]
// Reads and writes pass the idle, access, evaluate and output states to the result beat; the back
// end takes one command at a time. Queries alternate the issue and check states for each line walked.
// Restart or a check_enable write: a sweep over all 2^ADDR_BITS byte marks and the line counts.
// After reset the byte store, marks and line counts are cleared by a sweep over all 2^ADDR_BITS
// addresses; input tready stays low until that sweep ends. Reset is asynchronous, active low.
module uninitialized_read_checker import urc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 cfg_wdata_i,     // check_enable
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // [15:0] address, [23:16] write_data, [32:24] line_count, rest zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                 m_axis_tvalid_o,
  input  logic                 m_axis_tready_i,
  // [7:0] read_data
  output logic [M_TDATA_W-1:0] m_axis_tdata_o,
  // [0] uninit_read, [1] lines_ready, [2] invalidate
  output logic [M_TUSER_W-1:0] m_axis_tuser_o
);

  logic q_push, q_ready, q_valid, q_pop, init_busy;
  cmd_t push_cmd, head_cmd;
  res_t m_res;

  urc_front u_front (
    .s_axis_tvalid (s_axis_tvalid_i),
    .s_axis_tready (s_axis_tready_o),
    .s_axis_tdata  (s_axis_tdata_i),
    .s_axis_tuser  (s_axis_tuser_i),
    .q_ready_i     (q_ready),
    .init_busy_i   (init_busy),
    .q_push_o      (q_push),
    .q_cmd_o       (push_cmd)
  );

  urc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .ready_o (q_ready),
    .valid_o (q_valid),
    .cmd_o   (head_cmd),
    .pop_i   (q_pop)
  );

  urc_back #(
    .ADDR_BITS (ADDR_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_cmd_i     (head_cmd),
    .q_pop_o     (q_pop),
    .init_busy_o (init_busy),
    .m_valid_o   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_res_o     (m_res)
  );

  assign m_axis_tdata_o = m_res.rdata;
  assign m_axis_tuser_o = {m_res.inval, m_res.ready, m_res.uninit};

endmodule

[design/urc_front.sv]
// Front end: takes input beats, decodes the function and packs a command.
module urc_front import urc_pkg::*; (
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  input  logic                 q_ready_i,
  input  logic                 init_busy_i,
  output logic                 q_push_o,
  output cmd_t                 q_cmd_o
);

  op_e op;

  always_comb begin
    case (s_axis_tuser)
      FUNC_READ:    op = OP_READ;
      FUNC_WRITE:   op = OP_WRITE;
      FUNC_QUERY:   op = OP_QUERY;
      FUNC_RESTART: op = OP_RESTART;
      default:      op = OP_RESTART;
    endcase
  end

  // hold off input while the memories are being cleared after reset
  assign s_axis_tready = q_ready_i && !init_busy_i;
  assign q_push_o      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    q_cmd_o       = '0;
    q_cmd_o.op    = op;
    q_cmd_o.addr  = s_axis_tdata[ADDR_W-1:0];
    q_cmd_o.count = s_axis_tdata[ADDR_W+DATA_W+COUNT_W-1:ADDR_W+DATA_W];
    // only writes carry a byte
    if (op == OP_WRITE) begin
      q_cmd_o.wdata = s_axis_tdata[ADDR_W+DATA_W-1:ADDR_W];
    end
  end

endmodule

[design/urc_queue.sv]
// Short command queue between the front and back ends.
module urc_queue import urc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic ready_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] LastPtr = PW'(QUEUE_DEPTH - 1);
  localparam logic [NW-1:0] FullCnt = NW'(QUEUE_DEPTH);

  cmd_t          mem_q [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PW-1:0] rd_ptr_q, rd_ptr_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

[design/urc_back.sv]
// Back end: byte store, unwritten marks, per-line fill counts and the sequencer.
module urc_back import urc_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF,
  parameter int LINE_BITS = LINE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic cfg_wdata_i,
  input  logic q_valid_i,
  input  cmd_t q_cmd_i,
  output logic q_pop_o,
  output logic init_busy_o,
  output logic m_valid_o,
  input  logic m_ready_i,
  output res_t m_res_o
);

  localparam int LB       = ADDR_BITS - LINE_BITS;
  localparam int NUM_LINES = 1 << LB;
  localparam int MEM_SIZE = 1 << ADDR_BITS;
  localparam int CW       = LINE_BITS + 1;
  localparam int QW       = ((LB > COUNT_W) ? LB : COUNT_W) + 1;
  localparam int AW_EXT   = (ADDR_BITS > ADDR_W) ? ADDR_BITS : ADDR_W;
  localparam logic [CW-1:0] LineFull = CW'(1) << LINE_BITS;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_ACC    = 7'b0000010,
    S_EVAL   = 7'b0000100,
    S_QISSUE = 7'b0001000,
    S_QCHECK = 7'b0010000,
    S_SWEEP  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_e;

  // storage
  logic [DATA_W-1:0] data_mem [MEM_SIZE];
  logic              mark_mem [MEM_SIZE];   // 1 while the byte is unwritten
  logic [CW-1:0]     cnt_mem  [NUM_LINES];  // bytes written in the line since restart

  state_e            state_q, state_d;
  cmd_t              cmd_q, cmd_d;
  logic              en_q;
  logic              cfg_pend_q, cfg_pend_d;
  logic              clr_data_q, clr_data_d;
  logic              sweep_res_q, sweep_res_d;
  logic [ADDR_BITS-1:0] sweep_q, sweep_d;
  logic [QW-1:0]     lidx_q, lidx_d;
  logic [COUNT_W-1:0] rem_q, rem_d;
  res_t              res_q, res_d;
  res_t              m_res_q;
  logic              m_valid_q, m_valid_d;
  logic              m_load;

  logic [DATA_W-1:0] data_rd_q;
  logic              mark_rd_q;
  logic [CW-1:0]     cnt_rd_q;

  logic [AW_EXT-1:0]    addr_ext;
  logic [ADDR_BITS-1:0] addr;
  logic [LB-1:0]        line;
  logic                 line_done;
  logic [CW-1:0]        cnt_inc;
  logic                 in_sweep;

  logic                 data_we, mark_we, mark_wd, cnt_we;
  logic [DATA_W-1:0]    data_wd;
  logic [CW-1:0]        cnt_wd;
  logic [ADDR_BITS-1:0] byte_wa;
  logic [LB-1:0]        cnt_wa, cnt_ra;

  assign addr_ext  = AW_EXT'(cmd_q.addr);
  assign addr      = addr_ext[ADDR_BITS-1:0];
  assign line      = addr[ADDR_BITS-1:LINE_BITS];
  assign line_done = !en_q || (cnt_rd_q == LineFull);
  assign cnt_inc   = cnt_rd_q + 1'b1;
  assign in_sweep  = (state_q == S_SWEEP);

  assign byte_wa = in_sweep ? sweep_q : addr;
  assign cnt_wa  = in_sweep ? sweep_q[ADDR_BITS-1:LINE_BITS] : line;
  assign cnt_ra  = (state_q == S_QISSUE) ? lidx_q[LB-1:0] : line;

  assign init_busy_o = in_sweep && clr_data_q;
  assign m_valid_o   = m_valid_q;
  assign m_res_o     = m_res_q;

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    sweep_d     = sweep_q;
    clr_data_d  = clr_data_q;
    sweep_res_d = sweep_res_q;
    lidx_d      = lidx_q;
    rem_d       = rem_q;
    res_d       = res_q;
    q_pop_o     = 1'b0;
    m_load      = 1'b0;
    data_we     = 1'b0;
    data_wd     = cmd_q.wdata;
    mark_we     = 1'b0;
    mark_wd     = 1'b0;
    cnt_we      = 1'b0;
    cnt_wd      = cnt_inc;

    case (state_q)
      S_IDLE: begin
        if (cfg_pend_q) begin
          sweep_d     = '0;
          clr_data_d  = 1'b0;
          sweep_res_d = 1'b0;
          state_d     = S_SWEEP;
        end else if (q_valid_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = S_ACC;
        end
      end
      S_ACC: begin
        // byte and line reads go out this cycle for reads and writes
        case (cmd_q.op)
          OP_QUERY: begin
            lidx_d  = QW'(line);
            rem_d   = cmd_q.count;
            state_d = S_QISSUE;
          end
          OP_RESTART: begin
            sweep_d     = '0;
            clr_data_d  = 1'b0;
            sweep_res_d = 1'b1;
            state_d     = S_SWEEP;
          end
          default: state_d = S_EVAL;
        endcase
      end
      S_EVAL: begin
        res_d = '0;
        if (cmd_q.op == OP_READ) begin
          res_d.rdata  = data_rd_q;
          res_d.uninit = !line_done && mark_rd_q;
        end else begin
          data_we = 1'b1;
          if (!line_done && mark_rd_q) begin
            mark_we     = 1'b1;
            cnt_we      = 1'b1;
            res_d.inval = (cnt_inc == LineFull);
          end
        end
        state_d = S_OUT;
      end
      S_QISSUE: begin
        if (rem_q == '0) begin
          res_d       = '0;
          res_d.ready = 1'b1;
          state_d     = S_OUT;
        end else if (lidx_q[QW-1:LB] != '0) begin
          // ran off the last line
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          state_d = S_QCHECK;
        end
      end
      S_QCHECK: begin
        if (!line_done) begin
          res_d   = '0;
          state_d = S_OUT;
        end else begin
          lidx_d  = lidx_q + 1'b1;
          rem_d   = rem_q - 1'b1;
          state_d = S_QISSUE;
        end
      end
      S_SWEEP: begin
        mark_we = 1'b1;
        mark_wd = 1'b1;
        cnt_we  = 1'b1;
        cnt_wd  = '0;
        data_we = clr_data_q;
        data_wd = '0;
        sweep_d = sweep_q + 1'b1;
        if (&sweep_q) begin
          if (sweep_res_q) begin
            res_d       = '0;
            res_d.inval = 1'b1;
            state_d     = S_OUT;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_ready_i) begin
          m_load  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cfg_pend_d = cfg_pend_q;
    if (cfg_we_i) begin
      cfg_pend_d = 1'b1;
    end else if (state_q == S_IDLE) begin
      cfg_pend_d = 1'b0;
    end
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (m_load) begin
      m_valid_d = 1'b1;
    end else if (m_ready_i) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      clr_data_q  <= 1'b1;
      sweep_res_q <= 1'b0;
      sweep_q     <= '0;
      en_q        <= 1'b0;
      cfg_pend_q  <= 1'b0;
      m_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_data_q  <= clr_data_d;
      sweep_res_q <= sweep_res_d;
      sweep_q     <= sweep_d;
      cfg_pend_q  <= cfg_pend_d;
      m_valid_q   <= m_valid_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    lidx_q <= lidx_d;
    rem_q  <= rem_d;
    res_q  <= res_d;
    if (m_load) begin
      m_res_q <= res_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_we) begin
      data_mem[byte_wa] <= data_wd;
    end
    data_rd_q <= data_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[byte_wa] <= mark_wd;
    end
    mark_rd_q <= mark_mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // a line count must never step past full
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_we && state_q == S_EVAL) |-> (cnt_rd_q != LineFull))
    else $error("line fill count incremented past full");

  a_eval_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EVAL) |-> (cmd_q.op == OP_READ || cmd_q.op == OP_WRITE))
    else $error("byte access stage entered for a non-access command");

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> (state_q == S_IDLE && !cfg_pend_q))
    else $error("command popped while busy or with a pending restart");

  a_restart_inval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && $past(state_q) == S_SWEEP) |-> res_q.inval)
    else $error("restart result without invalidate");

  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy_o |-> !m_valid_q)
    else $error("result pending during power-up clear");

endmodule
